/* hdl/dqed_pkg.sv */
// Shared types, constants and the Gray-code direction function for the encoder decoder.
package dqed_pkg;

  localparam int THRESH_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [THRESH_BITS-1:0] thresh_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  typedef struct packed {
    thresh_t step;
    thresh_t second;
    thresh_t third;
  } thresholds_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  localparam cfg_index_t REG_STEP_THRESHOLD   = 2'd0;
  localparam cfg_index_t REG_SECOND_THRESHOLD = 2'd1;
  localparam cfg_index_t REG_THIRD_THRESHOLD  = 2'd2;

  localparam thresh_t STEP_THRESHOLD_RESET   = 8'd3;
  localparam thresh_t SECOND_THRESHOLD_RESET = 8'd31;
  localparam thresh_t THIRD_THRESHOLD_RESET  = 8'd63;

  localparam logic [1:0] POS_DETENT = 2'b11;
  localparam logic [1:0] POS_ARM    = 2'b00;

  // Clockwise order is 11, 01, 00, 10 and back to 11.
  function automatic logic [1:0] cw_successor(input logic [1:0] pos);
    logic [1:0] succ;
    unique case (pos)
      2'b00: succ = 2'b10;
      2'b01: succ = 2'b00;
      2'b10: succ = 2'b11;
      2'b11: succ = 2'b01;
      default: succ = 2'b00;
    endcase
    return succ;
  endfunction

  function automatic dir_t classify(input logic [1:0] new_pos, input logic [1:0] old_pos);
    dir_t dir;
    if (cw_successor(old_pos) == new_pos) begin
      dir = DIR_CW;
    end else if (cw_successor(new_pos) == old_pos) begin
      dir = DIR_CCW;
    end else begin
      dir = DIR_NONE;
    end
    return dir;
  endfunction

endpackage

/* hdl/dual_quadrature_encoder_decoder_core.sv */
// Dual quadrature encoder decoder with speed-compensated step output.
// An accepted sample is held in the input register, then its result in the output register.
// Throughput: one sample per cycle unless the output stalls; history is updated per sample.
// The input and output registers stall only when the output side holds back tready.
// Synchronous reset clears the encoder state, both registers' valid flags and
// restores the threshold defaults 3, 31 and 63.
module dual_quadrature_encoder_decoder_core #(
  parameter int HISTORY_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [3:0] encoder_sample, [7:4] zero
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [2:0] right_steps, [5:3] left_steps, [7:6] zero
  input  logic                       cfg_wr_en,
  input  dqed_pkg::cfg_index_t       cfg_index,
  input  dqed_pkg::thresh_t          cfg_data
);
  import dqed_pkg::*;

  thresholds_t             thr;
  logic                    in_valid;
  logic [3:0]              in_sample;
  logic                    out_valid;
  logic signed [2:0]       out_right;
  logic signed [2:0]       out_left;
  logic                    advance;

  logic [3:0]              last_position;
  logic [1:0]              armed_flags;
  logic [HISTORY_BITS-1:0] right_cw;
  logic [HISTORY_BITS-1:0] right_ccw;
  logic [HISTORY_BITS-1:0] left_cw;
  logic [HISTORY_BITS-1:0] left_ccw;

  logic [HISTORY_BITS-1:0] right_cw_next;
  logic [HISTORY_BITS-1:0] right_ccw_next;
  logic [HISTORY_BITS-1:0] left_cw_next;
  logic [HISTORY_BITS-1:0] left_ccw_next;
  logic                    right_armed_next;
  logic                    left_armed_next;
  logic signed [2:0]       right_steps_next;
  logic signed [2:0]       left_steps_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_left, out_right};

  dqed_track #(.HISTORY_BITS(HISTORY_BITS)) u_right (
    .cur        (in_sample[1:0]),
    .prev       (last_position[1:0]),
    .armed      (armed_flags[0]),
    .cw         (right_cw),
    .ccw        (right_ccw),
    .thr        (thr),
    .cw_next    (right_cw_next),
    .ccw_next   (right_ccw_next),
    .armed_next (right_armed_next),
    .steps      (right_steps_next)
  );

  dqed_track #(.HISTORY_BITS(HISTORY_BITS)) u_left (
    .cur        (in_sample[3:2]),
    .prev       (last_position[3:2]),
    .armed      (armed_flags[1]),
    .cw         (left_cw),
    .ccw        (left_ccw),
    .thr        (thr),
    .cw_next    (left_cw_next),
    .ccw_next   (left_ccw_next),
    .armed_next (left_armed_next),
    .steps      (left_steps_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.step   <= STEP_THRESHOLD_RESET;
      thr.second <= SECOND_THRESHOLD_RESET;
      thr.third  <= THIRD_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STEP_THRESHOLD:   thr.step   <= cfg_data;
        REG_SECOND_THRESHOLD: thr.second <= cfg_data;
        REG_THIRD_THRESHOLD:  thr.third  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_position <= '0;
      armed_flags   <= '0;
      right_cw      <= '0;
      right_ccw     <= '0;
      left_cw       <= '0;
      left_ccw      <= '0;
    end else begin
      if (advance) begin
        out_valid     <= 1'b1;
        last_position <= in_sample;
        armed_flags   <= {left_armed_next, right_armed_next};
        right_cw      <= right_cw_next;
        right_ccw     <= right_ccw_next;
        left_cw       <= left_cw_next;
        left_ccw      <= left_ccw_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_right <= right_steps_next;
      out_left  <= left_steps_next;
    end
  end

endmodule

/* hdl/dqed_track.sv */
// Next-state and step logic for one quadrature encoder.
module dqed_track #(
  parameter int HISTORY_BITS = 8
) (
  input  logic [1:0]               cur,
  input  logic [1:0]               prev,
  input  logic                     armed,
  input  logic [HISTORY_BITS-1:0]  cw,
  input  logic [HISTORY_BITS-1:0]  ccw,
  input  dqed_pkg::thresholds_t    thr,
  output logic [HISTORY_BITS-1:0]  cw_next,
  output logic [HISTORY_BITS-1:0]  ccw_next,
  output logic                     armed_next,
  output logic signed [2:0]        steps
);
  import dqed_pkg::*;

  localparam int CMP_BITS = (HISTORY_BITS > THRESH_BITS) ? HISTORY_BITS : THRESH_BITS;

  dir_t                    dir;
  logic [HISTORY_BITS-1:0] cw_sh;
  logic [HISTORY_BITS-1:0] ccw_sh;
  logic [CMP_BITS-1:0]     cw_ext;
  logic [CMP_BITS-1:0]     ccw_ext;
  logic [CMP_BITS-1:0]     step_ext;
  logic [CMP_BITS-1:0]     second_ext;
  logic [CMP_BITS-1:0]     third_ext;
  logic                    cw_fire;
  logic                    ccw_fire;
  logic [CMP_BITS-1:0]     fired_hist;
  logic [1:0]              count;

  always_comb begin
    dir = classify(cur, prev);
    unique case (dir)
      DIR_CW: begin
        cw_sh  = {cw[HISTORY_BITS-2:0], 1'b1};
        ccw_sh = {1'b0, ccw[HISTORY_BITS-1:1]};
      end
      DIR_CCW: begin
        cw_sh  = {1'b0, cw[HISTORY_BITS-1:1]};
        ccw_sh = {ccw[HISTORY_BITS-2:0], 1'b1};
      end
      default: begin
        cw_sh  = {1'b0, cw[HISTORY_BITS-1:1]};
        ccw_sh = {1'b0, ccw[HISTORY_BITS-1:1]};
      end
    endcase
    if (cur == POS_DETENT) begin
      cw_sh  = '0;
      ccw_sh = '0;
    end

    cw_ext     = CMP_BITS'(cw_sh);
    ccw_ext    = CMP_BITS'(ccw_sh);
    step_ext   = CMP_BITS'(thr.step);
    second_ext = CMP_BITS'(thr.second);
    third_ext  = CMP_BITS'(thr.third);

    cw_fire  = armed && (cw_ext >= step_ext);
    ccw_fire = armed && !cw_fire && (ccw_ext >= step_ext);
    fired_hist = cw_fire ? cw_ext : ccw_ext;

    count = 2'd1;
    if (fired_hist >= second_ext) begin
      count = (fired_hist >= third_ext) ? 2'd3 : 2'd2;
    end

    if (cur == prev) begin
      cw_next    = cw;
      ccw_next   = ccw;
      armed_next = armed;
      steps      = '0;
    end else begin
      cw_next    = (cw_fire || ccw_fire) ? '0 : cw_sh;
      ccw_next   = (cw_fire || ccw_fire) ? '0 : ccw_sh;
      armed_next = (armed && !cw_fire && !ccw_fire) || (cur == POS_ARM);
      if (cw_fire) begin
        steps = $signed({1'b0, count});
      end else if (ccw_fire) begin
        steps = -$signed({1'b0, count});
      end else begin
        steps = '0;
      end
    end
  end

endmodule

/* tb/dual_quadrature_encoder_decoder_core_test.sv */
// Self-checking testbench for the dual quadrature encoder decoder core.
module dual_quadrature_encoder_decoder_core_test;
  import dqed_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HB = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_STALL = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam cfg_index_t REG_UNUSED = 2'd3;
  localparam logic [1:0] CW_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};
  localparam logic [1:0] CCW_NEXT [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
  localparam int RIGHT = 0;
  localparam int LEFT = 1;

  typedef struct {
    logic signed [2:0] right;
    logic signed [2:0] left;
  } steps_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  cfg_index_t cfg_index = REG_STEP_THRESHOLD;
  thresh_t cfg_data = '0;

  dual_quadrature_encoder_decoder_core #(
    .HISTORY_BITS(HB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Decoder state mirrored by the testbench.
  thresholds_t thr;
  logic [3:0] last_pos;
  logic [1:0] armed;
  logic [HB-1:0] cw_hist [2];
  logic [HB-1:0] ccw_hist [2];

  steps_t pending_steps [$];
  int errors = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int step_results = 0;
  int double_steps = 0;
  int triple_steps = 0;
  int settings_used = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 6;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  logic [1:0] walk_pos [2];
  logic walk_cw [2];

  function automatic logic signed [2:0] step_magnitude(input logic [HB-1:0] h);
    logic signed [2:0] n;
    n = 3'sd1;
    if (h >= thr.second) begin
      n = 3'sd2;
      if (h >= thr.third) n = 3'sd3;
    end
    return n;
  endfunction

  function automatic logic signed [2:0] track_encoder(input int enc, input logic [1:0] cur,
                                                      input logic [1:0] prev);
    dir_t dir;
    logic signed [2:0] steps;
    steps = 3'sd0;
    if (CW_NEXT[prev] == cur) dir = DIR_CW;
    else if (CW_NEXT[cur] == prev) dir = DIR_CCW;
    else dir = DIR_NONE;
    case (dir)
      DIR_CW: begin
        cw_hist[enc] = {cw_hist[enc][HB-2:0], 1'b1};
        ccw_hist[enc] = ccw_hist[enc] >> 1;
      end
      DIR_CCW: begin
        cw_hist[enc] = cw_hist[enc] >> 1;
        ccw_hist[enc] = {ccw_hist[enc][HB-2:0], 1'b1};
      end
      default: begin
        cw_hist[enc] = cw_hist[enc] >> 1;
        ccw_hist[enc] = ccw_hist[enc] >> 1;
      end
    endcase
    if (cur == POS_DETENT) begin
      cw_hist[enc] = '0;
      ccw_hist[enc] = '0;
    end
    if (armed[enc]) begin
      if (cw_hist[enc] >= thr.step) begin
        steps = step_magnitude(cw_hist[enc]);
        armed[enc] = 1'b0;
        cw_hist[enc] = '0;
        ccw_hist[enc] = '0;
      end else if (ccw_hist[enc] >= thr.step) begin
        steps = -step_magnitude(ccw_hist[enc]);
        armed[enc] = 1'b0;
        cw_hist[enc] = '0;
        ccw_hist[enc] = '0;
      end
    end
    if (cur == POS_ARM) armed[enc] = 1'b1;
    return steps;
  endfunction

  function automatic steps_t predict_steps(input logic [3:0] sample);
    steps_t res;
    res.right = 3'sd0;
    res.left = 3'sd0;
    if (sample[1:0] != last_pos[1:0]) begin
      res.right = track_encoder(RIGHT, sample[1:0], last_pos[1:0]);
      last_pos[1:0] = sample[1:0];
    end
    if (sample[3:2] != last_pos[3:2]) begin
      res.left = track_encoder(LEFT, sample[3:2], last_pos[3:2]);
      last_pos[3:2] = sample[3:2];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [2:0] got, input logic [2:0] want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    steps_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_steps.size() == 0) begin
        $display("[%0t] MISMATCH result with no request outstanding, data %h",
                 $realtime, m_tdata);
        errors++;
      end else begin
        want = pending_steps.pop_front();
        results_checked++;
        if (m_tdata[2:0] !== want.right) report_mismatch("right_steps", m_tdata[2:0], want.right);
        if (m_tdata[5:3] !== want.left) report_mismatch("left_steps", m_tdata[5:3], want.left);
        if (want.right != 0) step_results++;
        if (want.left != 0) step_results++;
        if (want.right == 2 || want.right == -2 || want.left == 2 || want.left == -2)
          double_steps++;
        if (want.right == 3 || want.right == -3 || want.left == 3 || want.left == -3)
          triple_steps++;
      end
    end
  end

  // Result receiver with random idling and requested long hold-offs.
  always @(posedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left <= LONG_STALL;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without progress", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [3:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_steps.push_back(predict_steps(sample));
    samples_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_thresholds(input thresh_t step_val, input thresh_t second_val,
                                  input thresh_t third_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_STEP_THRESHOLD;
    cfg_data <= step_val;
    @(posedge clk);
    thr.step = step_val;
    cfg_index <= REG_SECOND_THRESHOLD;
    cfg_data <= second_val;
    @(posedge clk);
    thr.second = second_val;
    cfg_index <= REG_THIRD_THRESHOLD;
    cfg_data <= third_val;
    @(posedge clk);
    thr.third = third_val;
    // A write to the spare index must leave every threshold alone.
    cfg_index <= REG_UNUSED;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [1:0] next_walk_pos(input int enc);
    int r;
    logic [1:0] p;
    p = walk_pos[enc];
    r = $urandom_range(99);
    if ($urandom_range(99) < 5) walk_cw[enc] = ~walk_cw[enc];
    if (r < 75) p = walk_cw[enc] ? CW_NEXT[p] : CCW_NEXT[p];
    else if (r < 85) p = p;
    else if (r < 92) p = walk_cw[enc] ? CCW_NEXT[p] : CW_NEXT[p];
    else p = 2'($urandom_range(3));
    walk_pos[enc] = p;
    return p;
  endfunction

  task automatic run_rotation(input int count);
    logic [1:0] r;
    logic [1:0] l;
    repeat (count) begin
      r = next_walk_pos(RIGHT);
      l = next_walk_pos(LEFT);
      send_sample({l, r});
    end
  endtask

  task automatic test_directed_sequences();
    logic [3:0] seq [$];
    // Right turns clockwise while left turns counter-clockwise, then the reverse,
    // with unchanged samples and jumps of both bits mixed in.
    seq = '{4'hF, 4'h9, 4'h0, 4'h6, 4'hF, 4'h9, 4'h0, 4'h6, 4'hF, 4'hF,
            4'h0, 4'hF, 4'h5, 4'hA, 4'h5, 4'hF, 4'h6, 4'h0, 4'h9, 4'hF,
            4'h6, 4'h0, 4'h9, 4'hF};
    foreach (seq[i]) send_sample(seq[i]);
    walk_pos[RIGHT] = 2'b11;
    walk_pos[LEFT] = 2'b11;
    wait_idle();
  endtask

  task automatic test_threshold_sweep();
    apply_thresholds(8'd3, 8'd7, 8'd7);
    run_rotation(55);
    wait_idle();
    apply_thresholds(8'd1, 8'd3, 8'd7);
    run_rotation(55);
    wait_idle();
    apply_thresholds(8'd0, 8'd0, 8'd0);
    run_rotation(50);
    wait_idle();
    apply_thresholds(8'd255, 8'd255, 8'd255);
    run_rotation(40);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_thresholds(8'd2, 8'd3, 8'd255);
    run_rotation(60);
    wait_idle();
    send_idle_pct = 6;
    recv_idle_pct = 6;
    repeat (3) begin
      apply_thresholds(8'($urandom_range(8)), 8'($urandom_range(8)), 8'($urandom_range(8)));
      run_rotation(30);
      wait_idle();
    end
    apply_thresholds(STEP_THRESHOLD_RESET, SECOND_THRESHOLD_RESET, THIRD_THRESHOLD_RESET);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_requests++;
    run_rotation(45);
    send_idle_pct = 6;
    wait_idle();
  endtask

  initial begin
    thr.step = STEP_THRESHOLD_RESET;
    thr.second = SECOND_THRESHOLD_RESET;
    thr.third = THIRD_THRESHOLD_RESET;
    last_pos = '0;
    armed = '0;
    cw_hist = '{default: '0};
    ccw_hist = '{default: '0};
    walk_pos = '{default: 2'b00};
    walk_cw = '{1'b1, 1'b0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_sequences();
    test_threshold_sweep();
    test_output_backpressure();

    errors += pending_steps.size();
    $display("Checked %0d results from %0d samples over %0d threshold settings.",
             results_checked, samples_sent, settings_used);
    $display("Saw %0d encoder steps, %0d double and %0d triple, plus a long output stall.",
             step_results, double_steps, triple_steps);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
